/* rtl/jet_image_histogrammer_defines.svh */
// Assertion macros shared by the jet image histogrammer RTL.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef JET_IMAGE_HISTOGRAMMER_DEFINES_SVH
`define JET_IMAGE_HISTOGRAMMER_DEFINES_SVH
`ifndef SYNTHESIS
`define JIH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jih assertion failed");
`define JIH_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("jih forbidden condition seen");
`else
`define JIH_ASSERT(lbl, prop)
`define JIH_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/jih_pkg.sv */
// Package of the jet image histogrammer: grid constants, codes and payload types.
// Has no dependencies; used by the top level by scoped names.
package jih_pkg;

  localparam int GridEta  = 33;
  localparam int GridPhi  = 33;
  localparam int NumPix   = GridEta * GridPhi;
  localparam int NumClass = 5;
  localparam int MemAW    = $clog2(NumPix);
  localparam int EtaBinW  = $clog2(GridEta);
  localparam int PhiBinW  = $clog2(GridPhi);

  localparam int PixW     = 11;
  localparam int PtW      = 24;
  localparam int CntW     = 16;
  localparam int OffW     = 16;
  localparam int HalfW    = 15;
  localparam int ScaleW   = 16;
  localparam int MomW     = 16;
  localparam int IdW      = 32;
  localparam int CfgIdW   = 16;
  localparam int ProdW    = OffW + ScaleW;
  localparam int BinShift = 20;
  localparam int BinQW    = ProdW - BinShift;

  localparam int DataW    = 32;
  localparam int PAddrW   = 5;
  localparam int RegIdxW  = 3;

  localparam logic [PtW-1:0]  PtMax  = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic OpAccumulate = 1'b0;
  localparam logic OpRead       = 1'b1;

  localparam logic [RegIdxW-1:0] RegEtaHalf   = 3'd0;
  localparam logic [RegIdxW-1:0] RegPhiHalf   = 3'd1;
  localparam logic [RegIdxW-1:0] RegEtaScale  = 3'd2;
  localparam logic [RegIdxW-1:0] RegPhiScale  = 3'd3;
  localparam logic [RegIdxW-1:0] RegElectronId = 3'd4;
  localparam logic [RegIdxW-1:0] RegMuonId    = 3'd5;
  localparam logic [RegIdxW-1:0] RegPhotonId  = 3'd6;

  typedef enum logic [2:0] {
    ClsElectron,
    ClsMuon,
    ClsPhoton,
    ClsNeutral,
    ClsCharged
  } class_e;

  typedef struct packed {
    logic                   op;
    logic signed [OffW-1:0] delta_eta;
    logic signed [OffW-1:0] delta_phi;
    logic [MomW-1:0]        momentum;
    logic signed [IdW-1:0]  particle_id;
    logic [PixW-1:0]        read_pixel;
  } in_req_t;

  typedef struct packed {
    logic            in_window;
    logic [PixW-1:0] pixel_index;
    logic [PtW-1:0]  electron_pt_sum;
    logic [PtW-1:0]  muon_pt_sum;
    logic [PtW-1:0]  photon_pt_sum;
    logic [PtW-1:0]  neutral_pt_sum;
    logic [PtW-1:0]  charged_pt_sum;
    logic [CntW-1:0] electron_count;
    logic [CntW-1:0] muon_count;
    logic [CntW-1:0] photon_count;
    logic [CntW-1:0] neutral_count;
    logic [CntW-1:0] charged_count;
  } out_rsp_t;

  typedef struct packed {
    logic [NumClass-1:0][PtW-1:0]  pt;
    logic [NumClass-1:0][CntW-1:0] cnt;
  } row_t;

endpackage

/* rtl/jet_image_histogrammer.sv */
// Top level of the jet image histogrammer: binning pipeline and pixel memory.
// Depends on jih_pkg and jet_image_histogrammer_defines.svh.
//
//   channel  direction  handshake                  payload
//   in       in         in_valid_i / in_ready_o    in_req_i  (jih_pkg::in_req_t)
//   out      out        out_valid_o / out_ready_i  out_rsp_o (jih_pkg::out_rsp_t)
//   cfg      in         APB psel/penable/pready    paddr, pwdata, prdata
//
// One request per cycle is accepted unless the output stalls or the clearing pass runs;
// its result passes the input, product and memory read stages, then the output register.
// Each request that hits a pixel does one read-modify-write of a single pixel row, and a write
// still in flight is forwarded to the next request.
// After reset a clearing pass zeroes the memory; no request is accepted meanwhile.
// A stalled output holds the whole pipeline.
`include "jet_image_histogrammer_defines.svh"

module jet_image_histogrammer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  jih_pkg::in_req_t             in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output jih_pkg::out_rsp_t            out_rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [jih_pkg::PAddrW-1:0]   paddr,
  input  logic [jih_pkg::DataW-1:0]    pwdata,
  output logic [jih_pkg::DataW-1:0]    prdata,
  output logic                         pready
);

  typedef struct packed {
    logic                          op;
    logic                          in_win;
    jih_pkg::class_e               cls;
    logic [jih_pkg::MomW-1:0]      mom;
    logic [jih_pkg::PixW-1:0]      read_pixel;
    logic [jih_pkg::BinQW-1:0]     eta_bq;
    logic [jih_pkg::BinQW-1:0]     phi_bq;
  } s2_t;

  typedef struct packed {
    logic                          op;
    logic                          hit;
    logic                          in_win;
    jih_pkg::class_e               cls;
    logic [jih_pkg::MomW-1:0]      mom;
    logic [jih_pkg::MemAW-1:0]     addr;
    logic [jih_pkg::PixW-1:0]      pix;
  } s3_t;

  logic [jih_pkg::HalfW-1:0]  eta_half_q, phi_half_q;
  logic [jih_pkg::ScaleW-1:0] eta_scale_q, phi_scale_q;
  logic [jih_pkg::CfgIdW-1:0] electron_id_q, muon_id_q, photon_id_q;

  logic                       clr_active_q;
  logic [jih_pkg::MemAW-1:0]  clr_cnt_q;

  logic               s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q, fwd_valid_q;
  jih_pkg::in_req_t   s1_q;
  s2_t                s2_q, s2_d;
  s3_t                s3_q, s3_d;
  jih_pkg::out_rsp_t  out_rsp_q, rsp_d;
  jih_pkg::row_t      rdata_q, fwd_row_q, row_cur, row_new;
  logic [jih_pkg::MemAW-1:0] fwd_addr_q;

  jih_pkg::row_t      pix_mem_q [jih_pkg::NumPix];

  logic adv, in_acc, s3_we, mem_we, cfg_we;
  logic [jih_pkg::MemAW-1:0] mem_waddr;
  jih_pkg::row_t             mem_wdata;
  logic [jih_pkg::RegIdxW-1:0] reg_idx;

  // Stage 1 signals.
  logic [jih_pkg::OffW:0]   eta_ext, phi_ext, eta_mag, phi_mag, eta_sum, phi_sum;
  logic [jih_pkg::ProdW-1:0] eta_prod, phi_prod;
  logic [jih_pkg::IdW-1:0]  pid_u, abs_id;
  logic                     eta_in, phi_in;

  // Stage 2 signals.
  logic [jih_pkg::EtaBinW-1:0] eta_bin;
  logic [jih_pkg::PhiBinW-1:0] phi_bin;
  logic [jih_pkg::MemAW-1:0]   bin_pix, raddr;
  logic                        rd_in_grid;

  // Stage 3 signals.
  logic [jih_pkg::PtW:0]   pt_sum;
  logic [jih_pkg::PtW-1:0] pt_cur;
  logic [jih_pkg::CntW-1:0] cnt_cur;
  logic                    rd_hit;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv && !clr_active_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // Stage 1: window test, bin products and particle class.
  always_comb begin
    eta_ext  = {s1_q.delta_eta[jih_pkg::OffW-1], s1_q.delta_eta};
    phi_ext  = {s1_q.delta_phi[jih_pkg::OffW-1], s1_q.delta_phi};
    eta_mag  = eta_ext[jih_pkg::OffW] ? (~eta_ext + 1'b1) : eta_ext;
    phi_mag  = phi_ext[jih_pkg::OffW] ? (~phi_ext + 1'b1) : phi_ext;
    eta_in   = eta_mag < {2'b00, eta_half_q};
    phi_in   = phi_mag < {2'b00, phi_half_q};
    eta_sum  = eta_ext + {2'b00, eta_half_q};
    phi_sum  = phi_ext + {2'b00, phi_half_q};
    eta_prod = jih_pkg::ProdW'(eta_sum[jih_pkg::OffW-1:0]) * jih_pkg::ProdW'(eta_scale_q);
    phi_prod = jih_pkg::ProdW'(phi_sum[jih_pkg::OffW-1:0]) * jih_pkg::ProdW'(phi_scale_q);
    pid_u    = s1_q.particle_id;
    abs_id   = pid_u[jih_pkg::IdW-1] ? (~pid_u + 1'b1) : pid_u;

    s2_d.op         = s1_q.op;
    s2_d.in_win     = eta_in && phi_in;
    s2_d.mom        = s1_q.momentum;
    s2_d.read_pixel = s1_q.read_pixel;
    s2_d.eta_bq     = eta_prod[jih_pkg::ProdW-1:jih_pkg::BinShift];
    s2_d.phi_bq     = phi_prod[jih_pkg::ProdW-1:jih_pkg::BinShift];
    if (abs_id == jih_pkg::IdW'(electron_id_q)) begin
      s2_d.cls = jih_pkg::ClsElectron;
    end else if (abs_id == jih_pkg::IdW'(muon_id_q)) begin
      s2_d.cls = jih_pkg::ClsMuon;
    end else if (abs_id == jih_pkg::IdW'(photon_id_q)) begin
      s2_d.cls = jih_pkg::ClsPhoton;
    end else if (abs_id == '0) begin
      s2_d.cls = jih_pkg::ClsNeutral;
    end else begin
      s2_d.cls = jih_pkg::ClsCharged;
    end
  end

  // Stage 2: bin saturation, pixel index and memory read address.
  always_comb begin
    if (s2_q.eta_bq > jih_pkg::BinQW'(jih_pkg::GridEta - 1)) begin
      eta_bin = jih_pkg::EtaBinW'(jih_pkg::GridEta - 1);
    end else begin
      eta_bin = s2_q.eta_bq[jih_pkg::EtaBinW-1:0];
    end
    if (s2_q.phi_bq > jih_pkg::BinQW'(jih_pkg::GridPhi - 1)) begin
      phi_bin = jih_pkg::PhiBinW'(jih_pkg::GridPhi - 1);
    end else begin
      phi_bin = s2_q.phi_bq[jih_pkg::PhiBinW-1:0];
    end
    bin_pix    = jih_pkg::MemAW'(eta_bin) * jih_pkg::MemAW'(jih_pkg::GridPhi)
               + jih_pkg::MemAW'(phi_bin);
    rd_in_grid = int'(s2_q.read_pixel) < jih_pkg::NumPix;

    s3_d.op     = s2_q.op;
    s3_d.cls    = s2_q.cls;
    s3_d.mom    = s2_q.mom;
    s3_d.in_win = (s2_q.op == jih_pkg::OpAccumulate) && s2_q.in_win;
    if (s2_q.op == jih_pkg::OpRead) begin
      raddr    = jih_pkg::MemAW'(s2_q.read_pixel);
      s3_d.hit = rd_in_grid;
      s3_d.pix = s2_q.read_pixel;
    end else begin
      raddr    = bin_pix;
      s3_d.hit = s2_q.in_win;
      s3_d.pix = s2_q.in_win ? jih_pkg::PixW'(bin_pix) : '0;
    end
    s3_d.addr = raddr;
  end

  // Stage 3: modify the row, forwarding the write of the previous request.
  always_comb begin
    row_cur = (fwd_valid_q && (fwd_addr_q == s3_q.addr)) ? fwd_row_q : rdata_q;
    pt_cur  = row_cur.pt[s3_q.cls];
    cnt_cur = row_cur.cnt[s3_q.cls];
    pt_sum  = {1'b0, pt_cur} + (jih_pkg::PtW + 1)'(s3_q.mom);
    row_new = row_cur;
    if (s3_q.op == jih_pkg::OpRead) begin
      row_new = '0;
    end else begin
      row_new.pt[s3_q.cls]  = pt_sum[jih_pkg::PtW] ? jih_pkg::PtMax : pt_sum[jih_pkg::PtW-1:0];
      row_new.cnt[s3_q.cls] = (cnt_cur == jih_pkg::CntMax) ? cnt_cur : cnt_cur + 1'b1;
    end
    s3_we  = s3_valid_q && s3_q.hit;
    rd_hit = (s3_q.op == jih_pkg::OpRead) && s3_q.hit;

    rsp_d.in_window       = s3_q.in_win;
    rsp_d.pixel_index     = s3_q.pix;
    rsp_d.electron_pt_sum = rd_hit ? row_cur.pt[jih_pkg::ClsElectron]  : '0;
    rsp_d.muon_pt_sum     = rd_hit ? row_cur.pt[jih_pkg::ClsMuon]      : '0;
    rsp_d.photon_pt_sum   = rd_hit ? row_cur.pt[jih_pkg::ClsPhoton]    : '0;
    rsp_d.neutral_pt_sum  = rd_hit ? row_cur.pt[jih_pkg::ClsNeutral]   : '0;
    rsp_d.charged_pt_sum  = rd_hit ? row_cur.pt[jih_pkg::ClsCharged]   : '0;
    rsp_d.electron_count  = rd_hit ? row_cur.cnt[jih_pkg::ClsElectron] : '0;
    rsp_d.muon_count      = rd_hit ? row_cur.cnt[jih_pkg::ClsMuon]     : '0;
    rsp_d.photon_count    = rd_hit ? row_cur.cnt[jih_pkg::ClsPhoton]   : '0;
    rsp_d.neutral_count   = rd_hit ? row_cur.cnt[jih_pkg::ClsNeutral]  : '0;
    rsp_d.charged_count   = rd_hit ? row_cur.cnt[jih_pkg::ClsCharged]  : '0;
  end

  assign mem_we    = clr_active_q || (adv && s3_we);
  assign mem_waddr = clr_active_q ? clr_cnt_q : s3_q.addr;
  assign mem_wdata = clr_active_q ? '0 : row_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pix_mem_q[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rdata_q <= pix_mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q       <= in_req_i;
      s2_q       <= s2_d;
      s3_q       <= s3_d;
      fwd_addr_q <= s3_q.addr;
      fwd_row_q  <= row_new;
      if (s3_valid_q) begin
        out_rsp_q <= rsp_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      fwd_valid_q  <= 1'b0;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else begin
      if (adv) begin
        s1_valid_q  <= in_acc;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        out_valid_q <= s3_valid_q;
        fwd_valid_q <= s3_we;
      end
      if (clr_active_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == jih_pkg::MemAW'(jih_pkg::NumPix - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[jih_pkg::PAddrW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_half_q    <= 15'd1638;
      phi_half_q    <= 15'd1638;
      eta_scale_q   <= 16'd10560;
      phi_scale_q   <= 16'd10560;
      electron_id_q <= 16'd11;
      muon_id_q     <= 16'd13;
      photon_id_q   <= 16'd22;
    end else if (cfg_we) begin
      case (reg_idx)
        jih_pkg::RegEtaHalf:    eta_half_q    <= pwdata[jih_pkg::HalfW-1:0];
        jih_pkg::RegPhiHalf:    phi_half_q    <= pwdata[jih_pkg::HalfW-1:0];
        jih_pkg::RegEtaScale:   eta_scale_q   <= pwdata[jih_pkg::ScaleW-1:0];
        jih_pkg::RegPhiScale:   phi_scale_q   <= pwdata[jih_pkg::ScaleW-1:0];
        jih_pkg::RegElectronId: electron_id_q <= pwdata[jih_pkg::CfgIdW-1:0];
        jih_pkg::RegMuonId:     muon_id_q     <= pwdata[jih_pkg::CfgIdW-1:0];
        jih_pkg::RegPhotonId:   photon_id_q   <= pwdata[jih_pkg::CfgIdW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      jih_pkg::RegEtaHalf:    prdata = jih_pkg::DataW'(eta_half_q);
      jih_pkg::RegPhiHalf:    prdata = jih_pkg::DataW'(phi_half_q);
      jih_pkg::RegEtaScale:   prdata = jih_pkg::DataW'(eta_scale_q);
      jih_pkg::RegPhiScale:   prdata = jih_pkg::DataW'(phi_scale_q);
      jih_pkg::RegElectronId: prdata = jih_pkg::DataW'(electron_id_q);
      jih_pkg::RegMuonId:     prdata = jih_pkg::DataW'(muon_id_q);
      jih_pkg::RegPhotonId:   prdata = jih_pkg::DataW'(photon_id_q);
      default:                prdata = '0;
    endcase
  end

  `JIH_ASSERT_NEVER(a_no_accept_in_clear, clr_active_q && in_ready_o)
  `JIH_ASSERT(a_clear_done_stays, !clr_active_q |=> !clr_active_q)
  `JIH_ASSERT(a_read_zeroes_row, (!clr_active_q && mem_we && rd_hit) |-> (mem_wdata == '0))
  `JIH_ASSERT(a_acc_count_nonzero, (!clr_active_q && mem_we && !rd_hit) |-> (mem_wdata.cnt[s3_q.cls] != '0))
  `JIH_ASSERT(a_bin_in_grid, (out_valid_q && out_rsp_q.in_window) |-> (int'(out_rsp_q.pixel_index) < jih_pkg::NumPix))

endmodule

/* test/tb.sv */
// Self-checking testbench for the jet image histogrammer: drives constituent and pixel-read
// requests, predicts every result from its own copy of the pixel images and registers.
// Depends on jih_pkg and the jet_image_histogrammer RTL.
`timescale 1ns / 100ps

module tb;
  import jih_pkg::*;

  localparam int PipeLatency   = 4;
  localparam int StallLimit    = 4000;
  localparam int HoldOffCycles = 300;
  localparam int MaxReports    = 10;
  localparam logic [RegIdxW-1:0] RegUnused = 3'd7;

  typedef logic [11:0][PtW-1:0] field_vec_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_req_t             in_req_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_rsp_t            out_rsp_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PAddrW-1:0]   paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;

  jet_image_histogrammer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  logic [PtW-1:0]   pt_img  [NumClass][NumPix];
  logic [CntW-1:0]  cnt_img [NumClass][NumPix];
  logic [HalfW-1:0] cfg_eta_half   = 15'd1638;
  logic [HalfW-1:0] cfg_phi_half   = 15'd1638;
  logic [ScaleW-1:0] cfg_eta_scale = 16'd10560;
  logic [ScaleW-1:0] cfg_phi_scale = 16'd10560;
  logic [CfgIdW-1:0] cfg_electron_id = 16'd11;
  logic [CfgIdW-1:0] cfg_muon_id     = 16'd13;
  logic [CfgIdW-1:0] cfg_photon_id   = 16'd22;

  out_rsp_t    due_pixel_rsp[$];
  int unsigned hit_pixels[$];
  int          bad_results = 0;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off_go = 1'b0;

  string field_names[12] = '{"in_window", "pixel_index", "electron_pt_sum", "muon_pt_sum",
                             "photon_pt_sum", "neutral_pt_sum", "charged_pt_sum",
                             "electron_count", "muon_count", "photon_count",
                             "neutral_count", "charged_count"};

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    for (int c = 0; c < NumClass; c++) begin
      for (int p = 0; p < NumPix; p++) begin
        pt_img[c][p]  = '0;
        cnt_img[c][p] = '0;
      end
    end
  end

  function automatic bit offset_fits(int off, int unsigned half);
    return ((off < 0) ? -off : off) < int'(half);
  endfunction

  function automatic int unsigned bin_index(int off, int unsigned half, int unsigned scale,
                                            int unsigned nbins);
    longint bin_no;
    bin_no = (longint'(off + int'(half)) * longint'(scale)) >>> BinShift;
    return (bin_no > nbins - 1) ? nbins - 1 : int'(bin_no);
  endfunction

  function automatic int unsigned pixel_at(int de, int dp);
    return bin_index(de, cfg_eta_half, cfg_eta_scale, GridEta) * GridPhi
         + bin_index(dp, cfg_phi_half, cfg_phi_scale, GridPhi);
  endfunction

  // Applies one request to the predicted images and returns the result it must produce.
  function automatic out_rsp_t histogram_step(in_req_t req);
    out_rsp_t       rsp;
    int             de;
    int             dp;
    int unsigned    pix;
    logic [IdW-1:0] abs_pid;
    class_e         cls;
    logic [PtW:0]   pt_total;
    rsp = '0;
    if (req.op == OpRead) begin
      rsp.pixel_index = req.read_pixel;
      if (req.read_pixel < NumPix) begin
        pix = req.read_pixel;
        rsp.electron_pt_sum = pt_img[ClsElectron][pix];
        rsp.muon_pt_sum     = pt_img[ClsMuon][pix];
        rsp.photon_pt_sum   = pt_img[ClsPhoton][pix];
        rsp.neutral_pt_sum  = pt_img[ClsNeutral][pix];
        rsp.charged_pt_sum  = pt_img[ClsCharged][pix];
        rsp.electron_count  = cnt_img[ClsElectron][pix];
        rsp.muon_count      = cnt_img[ClsMuon][pix];
        rsp.photon_count    = cnt_img[ClsPhoton][pix];
        rsp.neutral_count   = cnt_img[ClsNeutral][pix];
        rsp.charged_count   = cnt_img[ClsCharged][pix];
        for (int c = 0; c < NumClass; c++) begin
          pt_img[c][pix]  = '0;
          cnt_img[c][pix] = '0;
        end
      end
      return rsp;
    end
    de = $signed(req.delta_eta);
    dp = $signed(req.delta_phi);
    if (!offset_fits(de, cfg_eta_half) || !offset_fits(dp, cfg_phi_half)) begin
      return rsp;
    end
    pix = pixel_at(de, dp);
    abs_pid = req.particle_id[IdW-1] ? (~req.particle_id + 1'b1) : req.particle_id;
    if (abs_pid == cfg_electron_id) begin
      cls = ClsElectron;
    end else if (abs_pid == cfg_muon_id) begin
      cls = ClsMuon;
    end else if (abs_pid == cfg_photon_id) begin
      cls = ClsPhoton;
    end else if (abs_pid == 0) begin
      cls = ClsNeutral;
    end else begin
      cls = ClsCharged;
    end
    pt_total = pt_img[cls][pix] + req.momentum;
    pt_img[cls][pix] = (pt_total > PtMax) ? PtMax : pt_total[PtW-1:0];
    if (cnt_img[cls][pix] != CntMax) begin
      cnt_img[cls][pix] = cnt_img[cls][pix] + 1'b1;
    end
    rsp.in_window   = 1'b1;
    rsp.pixel_index = pix[PixW-1:0];
    hit_pixels.push_back(pix);
    if (hit_pixels.size() > 32) begin
      void'(hit_pixels.pop_front());
    end
    return rsp;
  endfunction

  function automatic field_vec_t split_fields(out_rsp_t r);
    field_vec_t f;
    f = '0;
    f[0]  = r.in_window;
    f[1]  = r.pixel_index;
    f[2]  = r.electron_pt_sum;
    f[3]  = r.muon_pt_sum;
    f[4]  = r.photon_pt_sum;
    f[5]  = r.neutral_pt_sum;
    f[6]  = r.charged_pt_sum;
    f[7]  = r.electron_count;
    f[8]  = r.muon_count;
    f[9]  = r.photon_count;
    f[10] = r.neutral_count;
    f[11] = r.charged_count;
    return f;
  endfunction

  function automatic in_req_t acc_req(int de, int dp, int unsigned pt, logic [IdW-1:0] pid);
    in_req_t req;
    req.op          = OpAccumulate;
    req.delta_eta   = de[OffW-1:0];
    req.delta_phi   = dp[OffW-1:0];
    req.momentum    = pt[MomW-1:0];
    req.particle_id = pid;
    req.read_pixel  = $urandom_range(2**PixW - 1);
    return req;
  endfunction

  function automatic in_req_t read_req(int unsigned pix);
    in_req_t req;
    req.op          = OpRead;
    req.delta_eta   = $urandom_range(2**OffW - 1);
    req.delta_phi   = $urandom_range(2**OffW - 1);
    req.momentum    = $urandom_range(2**MomW - 1);
    req.particle_id = $urandom;
    req.read_pixel  = pix[PixW-1:0];
    return req;
  endfunction

  function automatic int rand_offset(int unsigned half);
    int unsigned pick;
    pick = $urandom_range(99);
    if (half == 0 || pick < 10) begin
      return int'($urandom_range(2**OffW - 1)) - 2**(OffW - 1);
    end
    if (pick < 16) begin
      return pick[0] ? int'(half) : -int'(half);
    end
    return int'($urandom_range(2 * half - 2)) - int'(half) + 1;
  endfunction

  function automatic logic [IdW-1:0] rand_pid();
    logic [IdW-1:0] pid;
    case ($urandom_range(9))
      0: pid = cfg_electron_id;
      1: pid = cfg_muon_id;
      2: pid = cfg_photon_id;
      3: pid = '0;
      4: pid = 211;
      5: pid = 2212;
      default: pid = $urandom;
    endcase
    return $urandom_range(1) ? (~pid + 1'b1) : pid;
  endfunction

  function automatic in_req_t rand_req();
    int unsigned pick;
    int unsigned pix;
    int unsigned pt;
    pick = $urandom_range(99);
    if (pick < 22) begin
      pick = $urandom_range(99);
      if (pick < 60 && hit_pixels.size() != 0) begin
        pix = hit_pixels[$urandom_range(hit_pixels.size() - 1)];
      end else if (pick < 90) begin
        pix = $urandom_range(NumPix - 1);
      end else begin
        pix = $urandom_range(2**PixW - 1);
      end
      return read_req(pix);
    end
    pick = $urandom_range(9);
    pt = (pick == 0) ? 0 : (pick == 1) ? 2**MomW - 1 : $urandom_range(2**MomW - 1);
    return acc_req(rand_offset(cfg_eta_half), rand_offset(cfg_phi_half), pt, rand_pid());
  endfunction

  task automatic send_req(input in_req_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    due_pixel_rsp.push_back(histogram_step(req));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_pixel_rsp.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegEtaHalf:    cfg_eta_half    = value[HalfW-1:0];
      RegPhiHalf:    cfg_phi_half    = value[HalfW-1:0];
      RegEtaScale:   cfg_eta_scale   = value[ScaleW-1:0];
      RegPhiScale:   cfg_phi_scale   = value[ScaleW-1:0];
      RegElectronId: cfg_electron_id = value[CfgIdW-1:0];
      RegMuonId:     cfg_muon_id     = value[CfgIdW-1:0];
      RegPhotonId:   cfg_photon_id   = value[CfgIdW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [DataW-1:0] eta_half, input logic [DataW-1:0] phi_half,
                          input logic [DataW-1:0] eta_scale, input logic [DataW-1:0] phi_scale,
                          input logic [DataW-1:0] e_id, input logic [DataW-1:0] m_id,
                          input logic [DataW-1:0] p_id);
    drain();
    write_reg(RegEtaHalf, eta_half);
    write_reg(RegPhiHalf, phi_half);
    write_reg(RegEtaScale, eta_scale);
    write_reg(RegPhiScale, phi_scale);
    write_reg(RegElectronId, e_id);
    write_reg(RegMuonId, m_id);
    write_reg(RegPhotonId, p_id);
  endtask

  task automatic send_random(input int unsigned n_items);
    repeat (n_items) send_req(rand_req());
  endtask

  task automatic test_directed_cases();
    send_req(acc_req(0, 0, 65535, 11));
    send_req(acc_req(0, 0, 0, -11));
    send_req(acc_req(0, 0, 7, 13));
    send_req(acc_req(0, 0, 9, -13));
    send_req(acc_req(0, 0, 3, 22));
    send_req(acc_req(0, 0, 4, 0));
    send_req(acc_req(0, 0, 5, 32'h8000_0000));
    send_req(acc_req(0, 0, 6, 32'h7FFF_FFFF));
    send_req(read_req(pixel_at(0, 0)));
    send_req(read_req(pixel_at(0, 0)));
    send_req(acc_req(1637, -1637, 2, 211));
    send_req(acc_req(-1637, 1637, 65535, -22));
    send_req(acc_req(1638, 0, 1, 11));
    send_req(acc_req(0, -1638, 1, 11));
    send_req(acc_req(-1638, 0, 1, 0));
    send_req(acc_req(-32768, 32767, 1, 13));
    send_req(acc_req(32767, -32768, 1, 22));
    send_req(read_req(pixel_at(1637, -1637)));
    send_req(read_req(pixel_at(-1637, 1637)));
    send_req(read_req(0));
    send_req(read_req(NumPix - 1));
    send_req(read_req(NumPix));
    send_req(read_req(2**PixW - 1));
  endtask

  task automatic test_register_extremes();
    set_regs(32'd0, 32'd32767, 32'd0, 32'hFFFF, 32'd0, 32'd0, 32'd0);
    send_random(40);
    set_regs(32'hFFFF_FFFF, 32'd32767, 32'hFFFF, 32'hFFFF, 32'd0, 32'hFFFF, 32'hFFFF);
    send_random(40);
    set_regs(32'd32767, 32'd32767, 32'd0, 32'd0, 32'hFFFF, 32'd1, 32'd0);
    send_random(40);
    set_regs($urandom_range(1, 32767), $urandom_range(1, 32767), $urandom, $urandom,
             $urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 30));
    send_random(40);
    drain();
    write_reg(RegUnused, $urandom);
    set_regs(32'd1638, 32'd1638, 32'd10560, 32'd10560, 32'd11, 32'd13, 32'd22);
    send_random(40);
  endtask

  // Each block of requests runs under a fresh window, with scales that roughly fit the grid.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned eta_half;
    int unsigned phi_half;
    int unsigned eta_scale;
    int unsigned phi_scale;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 125 == 0) begin
        if ($urandom_range(3) == 0) begin
          set_regs(32'd1638, 32'd1638, 32'd10560, 32'd10560, 32'd11, 32'd13, 32'd22);
        end else begin
          eta_half  = $urandom_range(300, 20000);
          phi_half  = $urandom_range(300, 20000);
          eta_scale = (GridEta << BinShift) / (2 * eta_half) + $urandom_range(600) - 300;
          phi_scale = (GridPhi << BinShift) / (2 * phi_half) + $urandom_range(600) - 300;
          set_regs(eta_half, phi_half, eta_scale, phi_scale, $urandom_range(1, 40),
                   $urandom_range(1, 40), $urandom_range(1, 40));
        end
      end
      send_req(rand_req());
    end
  endtask

  task automatic test_output_stall();
    hold_off_go = 1'b1;
    send_random(60);
    drain();
  endtask

  // With zero scales all hits land on pixel zero; the charged sum and count saturate.
  task automatic test_saturation();
    set_regs(32'd32767, 32'd32767, 32'd0, 32'd0, 32'd11, 32'd13, 32'd22);
    for (int i = 0; i < 300; i++) begin
      send_req(acc_req(rand_offset(cfg_eta_half), rand_offset(cfg_phi_half), 65535, 11));
    end
    for (int i = 0; i < 65540; i++) begin
      send_req(acc_req(int'($urandom_range(65532)) - 32766, 0, 65535, -211));
    end
    send_req(read_req(0));
    send_req(read_req(0));
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    out_rsp_t   want;
    field_vec_t got_f;
    field_vec_t want_f;
    bit         bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_pixel_rsp.size() == 0) begin
        if (bad_results < MaxReports) begin
          $display("Result for pixel %0d arrived with no request outstanding.",
                   out_rsp_o.pixel_index);
        end
        bad_results++;
      end else begin
        want   = due_pixel_rsp.pop_front();
        got_f  = split_fields(out_rsp_o);
        want_f = split_fields(want);
        bad    = 1'b0;
        for (int k = 0; k < 12; k++) begin
          if (got_f[k] !== want_f[k]) begin
            if (bad_results < MaxReports) begin
              $display("Pixel %0d, %s: expected %0d, got %0d", want.pixel_index,
                       field_names[k], want_f[k], got_f[k]);
            end
            bad = 1'b1;
          end
        end
        if (bad) begin
          bad_results++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pwrite && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    send_idle_pct = 8;
    recv_idle_pct = 60;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_register_extremes();
    send_idle_pct = 60;
    recv_idle_pct = 8;
    test_random_traffic(500);
    test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(500);
    test_saturation();
    drain();
    repeat (2 * PipeLatency) @(posedge clk_i);
    bad_results += due_pixel_rsp.size();
    if (bad_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
